>>> src/glyc_pkg.sv
// Shared constants, types and codes of the glyph cache tag directory.
package glyc_pkg;

    // Geometry of the directory.
    localparam int SETS    = 128;
    localparam int WAYS    = 16;
    localparam int ENTRIES = SETS * WAYS;
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRY_W = $clog2(ENTRIES);

    // Field widths.
    localparam int OP_W   = 2;
    localparam int CODE_W = 21;
    localparam int ATTR_W = 32;
    localparam int SLOT_W = 11;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SET_CHK,
        ST_TAG_RD,
        ST_TAG_CMP
    } state_t;

    // One stored tag.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [ATTR_W-1:0] fg;
        logic [ATTR_W-1:0] bg;
    } tag_t;

    // Per-set bookkeeping: valid bit of each way and the replacement pointer.
    typedef struct packed {
        logic [WAYS-1:0]  valid;
        logic [WAY_W-1:0] next_way;
    } set_row_t;

    // Command word to the tag store.
    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [ENTRY_W-1:0] addr;
        tag_t               wdata;
    } tag_cmd_t;

    // Command word to the set state store.
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [SET_W-1:0] addr;
        set_row_t         wdata;
    } set_cmd_t;

endpackage

>>> src/glyph_cache_set_assoc_fifo_unit.sv
// Top level of the glyph cache tag directory: sequencer, input and result registers.
//
// A command word is taken when start is high and busy is low; its single result
// word (hit, slot) appears in the cycle in which busy falls, for one cycle, marked by
// done, and must be captured then. An insert holds busy high for its set check step
// only; no new word is taken while busy is high. A lookup scans the ways of its set
// one at a time through the single tag read port and comparator, a tag read step and
// a tag compare step per way, until a way hits or the last way misses. A clear walks
// the set state memory one row a cycle and holds busy until all SETS rows are written;
// the same pass runs after reset, with busy high and no result word. Operation code
// three produces its result word in the cycle after it is taken, without raising busy.
module glyph_cache_set_assoc_fifo_unit
    import glyc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   operation,
    input  logic [CODE_W-1:0] char_code,
    input  logic [ATTR_W-1:0] fg_attr,
    input  logic [ATTR_W-1:0] bg_attr,
    output logic              done,
    output logic              hit,
    output logic [SLOT_W-1:0] slot
);

    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg;
    logic [CODE_W-1:0] code_reg;
    logic [ATTR_W-1:0] fg_reg, bg_reg;
    logic              load_in;
    logic [WAY_W-1:0]  way_reg, way_next;
    logic [SET_W-1:0]  clr_addr_reg, clr_addr_next;
    logic              clr_report_reg, clr_report_next;
    logic              done_reg, done_next;
    logic              hit_reg, hit_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    tag_cmd_t          tag_cmd;
    set_cmd_t          set_cmd;
    tag_t              key;
    logic              tag_match;
    set_row_t          set_row;

    logic [SET_W-1:0]  cur_set;
    logic [WAY_W-1:0]  ins_way, ins_way_inc;
    logic              clr_last, way_last, way_hit;

    // Storage and the shared comparator.
    glyc_tag_unit u_tag (
        .clk   (clk),
        .cmd   (tag_cmd),
        .key   (key),
        .match (tag_match)
    );

    glyc_set_unit u_set (
        .clk   (clk),
        .cmd   (set_cmd),
        .rdata (set_row)
    );

    // Decoded helpers. The set is the low bits of the code, SETS being a power of two.
    assign cur_set     = code_reg[SET_W-1:0];
    assign key         = '{code: code_reg, fg: fg_reg, bg: bg_reg};
    assign ins_way     = ({1'b0, set_row.next_way} >= (WAY_W + 1)'(WAYS))
                         ? '0 : set_row.next_way;
    assign ins_way_inc = (ins_way == WAY_W'(WAYS - 1)) ? '0 : ins_way + WAY_W'(1);
    assign clr_last    = (clr_addr_reg == SET_W'(SETS - 1));
    assign way_last    = (way_reg == WAY_W'(WAYS - 1));
    assign way_hit     = set_row.valid[way_reg] && tag_match;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (operation)
                        OP_LOOKUP, OP_INSERT: state_next = ST_SET_CHK;
                        OP_CLEAR:             state_next = ST_INIT;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SET_CHK:
            begin
                state_next = (op_reg == OP_LOOKUP) ? ST_TAG_RD : ST_IDLE;
            end
            ST_TAG_RD:
            begin
                state_next = ST_TAG_CMP;
            end
            ST_TAG_CMP:
            begin
                state_next = (way_hit || way_last) ? ST_IDLE : ST_TAG_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory commands, counters and result words.
    always_comb
    begin
        tag_cmd         = '0;
        set_cmd         = '0;
        load_in         = 1'b0;
        way_next        = way_reg;
        clr_addr_next   = clr_addr_reg;
        clr_report_next = clr_report_reg;
        done_next       = 1'b0;
        hit_next        = 1'b0;
        slot_next       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    load_in = 1'b1;
                    unique case (operation)
                        OP_LOOKUP, OP_INSERT:
                        begin
                            set_cmd.rd_en = 1'b1;
                            set_cmd.addr  = char_code[SET_W-1:0];
                        end
                        OP_CLEAR:
                        begin
                            clr_addr_next   = '0;
                            clr_report_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                set_cmd.wr_en = 1'b1;
                set_cmd.addr  = clr_addr_reg;
                set_cmd.wdata = '0;
                clr_addr_next = clr_addr_reg + SET_W'(1);
                if (clr_last)
                begin
                    done_next = clr_report_reg;
                end
            end
            ST_SET_CHK:
            begin
                if (op_reg == OP_INSERT)
                begin
                    // Write the tag at the FIFO pointer, mark it valid, advance the pointer.
                    tag_cmd.wr_en = 1'b1;
                    tag_cmd.addr  = {cur_set, ins_way};
                    tag_cmd.wdata = key;
                    set_cmd.wr_en = 1'b1;
                    set_cmd.addr  = cur_set;
                    set_cmd.wdata.valid          = set_row.valid;
                    set_cmd.wdata.valid[ins_way] = 1'b1;
                    set_cmd.wdata.next_way       = ins_way_inc;
                    done_next = 1'b1;
                    slot_next = SLOT_W'({cur_set, ins_way});
                end
                else
                begin
                    way_next = '0;
                end
            end
            ST_TAG_RD:
            begin
                tag_cmd.rd_en = 1'b1;
                tag_cmd.addr  = {cur_set, way_reg};
            end
            ST_TAG_CMP:
            begin
                // The lowest matching way wins since ways are scanned upward.
                if (way_hit)
                begin
                    done_next = 1'b1;
                    hit_next  = 1'b1;
                    slot_next = SLOT_W'({cur_set, way_reg});
                end
                else if (way_last)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    way_next = way_reg + WAY_W'(1);
                end
            end
            default:
            begin
                way_next = way_reg;
            end
        endcase
    end

    // Control registers. Reset starts the clearing pass of the set state memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            way_reg        <= '0;
            clr_addr_reg   <= '0;
            clr_report_reg <= 1'b0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            slot_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            way_reg        <= way_next;
            clr_addr_reg   <= clr_addr_next;
            clr_report_reg <= clr_report_next;
            done_reg       <= done_next;
            hit_reg        <= hit_next;
            slot_reg       <= slot_next;
        end
    end

    // Captured command word.
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            op_reg   <= operation;
            code_reg <= char_code;
            fg_reg   <= fg_attr;
            bg_reg   <= bg_attr;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign hit  = hit_reg;
    assign slot = slot_reg;

    // An accepted clear always runs the clearing pass.
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation == OP_CLEAR |=> busy)
        else $error("clear accepted without entering the clearing pass");

    // A hit can only come out of a tag compare step.
    a_hit_src: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> done && $past(state_reg) == ST_TAG_CMP)
        else $error("hit reported outside a tag compare");

    // No result word appears while the clearing pass runs.
    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INIT |-> !done)
        else $error("result word during clearing pass");

endmodule

>>> src/glyc_tag_unit.sv
// Tag store with a registered read port and the shared tag comparator.
module glyc_tag_unit
    import glyc_pkg::*;
(
    input  logic     clk,
    input  tag_cmd_t cmd,
    input  tag_t     key,
    output logic     match
);

    tag_t mem [ENTRIES];
    tag_t rdata_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[cmd.addr];
        end
    end

    // The one comparator, reused for every way of a lookup.
    assign match = (rdata_reg == key);

endmodule

>>> src/glyc_set_unit.sv
// Per-set valid bits and replacement pointers, held in a small memory.
module glyc_set_unit
    import glyc_pkg::*;
(
    input  logic     clk,
    input  set_cmd_t cmd,
    output set_row_t rdata
);

    set_row_t mem [SETS];
    set_row_t rdata_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[cmd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the glyph cache tag directory with its own directory predictor.
module tb;
    import glyc_pkg::*;

    // Operation code that the block treats as a no-op.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int GAP_MAX      = 6;
    localparam int RANDOM_WORDS = 1125;
    localparam int HIST_DEPTH   = 48;
    localparam int CYCLE_LIMIT  = 1000000;
    // Longer than a full miss scan plus the result cycle.
    localparam int TAIL_CYCLES  = 40;

    localparam logic [CODE_W-1:0] CODE_MAX  = '1;
    localparam logic [ATTR_W-1:0] ATTR_ONES = '1;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [CODE_W-1:0] code;
        logic [ATTR_W-1:0] fg;
        logic [ATTR_W-1:0] bg;
        int                gap;
    } cmd_word_t;

    typedef struct {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } result_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   operation = '0;
    logic [CODE_W-1:0] char_code = '0;
    logic [ATTR_W-1:0] fg_attr = '0;
    logic [ATTR_W-1:0] bg_attr = '0;
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] slot;

    cmd_word_t    cmd_queue[$];
    result_word_t expected_results[$];
    tag_t         recent_tags[$];

    int sent_cnt = 0;
    int taken_cnt = 0;
    int gap_left = 0;
    int mismatches = 0;
    int cycles = 0;

    // Predicted directory contents.
    logic [CODE_W-1:0] dir_code [ENTRIES];
    logic [ATTR_W-1:0] dir_fg [ENTRIES];
    logic [ATTR_W-1:0] dir_bg [ENTRIES];
    logic              dir_valid [ENTRIES];
    int                dir_next [SETS];

    glyph_cache_set_assoc_fifo_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .char_code (char_code),
        .fg_attr   (fg_attr),
        .bg_attr   (bg_attr),
        .done      (done),
        .hit       (hit),
        .slot      (slot)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Invalidate every entry and rewind every replacement pointer.
    function automatic void clear_directory();
        int i;
        for (i = 0; i < ENTRIES; i++)
        begin
            dir_valid[i] = 1'b0;
        end
        for (i = 0; i < SETS; i++)
        begin
            dir_next[i] = 0;
        end
    endfunction

    // Update the predicted directory for one accepted word and return its result.
    function automatic result_word_t apply_command(cmd_word_t w);
        result_word_t r;
        int set_idx;
        int base;
        int way;
        int e;
        r.hit   = 1'b0;
        r.slot  = '0;
        set_idx = int'(w.code) % SETS;
        base    = set_idx * WAYS;
        if (w.op == OP_LOOKUP)
        begin
            // First matching valid way wins.
            for (way = 0; way < WAYS; way++)
            begin
                e = base + way;
                if (!r.hit && dir_valid[e] && dir_code[e] == w.code &&
                    dir_fg[e] == w.fg && dir_bg[e] == w.bg)
                begin
                    r.hit  = 1'b1;
                    r.slot = SLOT_W'(e);
                end
            end
        end
        else if (w.op == OP_INSERT)
        begin
            way = dir_next[set_idx];
            if (way >= WAYS)
            begin
                way = 0;
            end
            e            = base + way;
            dir_code[e]  = w.code;
            dir_fg[e]    = w.fg;
            dir_bg[e]    = w.bg;
            dir_valid[e] = 1'b1;
            dir_next[set_idx] = (way + 1 >= WAYS) ? 0 : way + 1;
            r.slot = SLOT_W'(e);
        end
        else if (w.op == OP_CLEAR)
        begin
            clear_directory();
        end
        return r;
    endfunction

    // Queue one command word with the idle time that follows it.
    function automatic void add_word(logic [OP_W-1:0] op, logic [CODE_W-1:0] code,
                                     logic [ATTR_W-1:0] fg, logic [ATTR_W-1:0] bg, int gap);
        cmd_word_t w;
        w.op   = op;
        w.code = code;
        w.fg   = fg;
        w.bg   = bg;
        w.gap  = gap;
        cmd_queue.push_back(w);
    endfunction

    // Remember an inserted tag so that later lookups can hit it.
    function automatic void remember_tag(tag_t t);
        recent_tags.push_back(t);
        if (recent_tags.size() > HIST_DEPTH)
        begin
            void'(recent_tags.pop_front());
        end
    endfunction

    // Driver: present the next word once the previous one is taken and its idle time is over.
    always @(negedge clk)
    begin
        cmd_word_t w;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && taken_cnt != sent_cnt)
        begin
            start <= 1'b1;
        end
        else if (gap_left > 0)
        begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (cmd_queue.size() > 0)
        begin
            w = cmd_queue.pop_front();
            operation <= w.op;
            char_code <= w.code;
            fg_attr   <= w.fg;
            bg_attr   <= w.bg;
            start     <= 1'b1;
            gap_left  <= w.gap;
            sent_cnt  <= sent_cnt + 1;
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // Monitor: check each result word, then predict the word taken at this edge.
    always @(posedge clk)
    begin
        cmd_word_t    w;
        result_word_t exp_word;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual hit %0b slot %0d",
                             $time, hit, slot);
                    mismatches++;
                end
                else
                begin
                    exp_word = expected_results.pop_front();
                    if (hit !== exp_word.hit)
                    begin
                        $display("%0t: hit mismatch, expected %0b, actual %0b",
                                 $time, exp_word.hit, hit);
                        mismatches++;
                    end
                    if (slot !== exp_word.slot)
                    begin
                        $display("%0t: slot mismatch, expected %0d, actual %0d",
                                 $time, exp_word.slot, slot);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                w.op   = operation;
                w.code = char_code;
                w.fg   = fg_attr;
                w.bg   = bg_attr;
                w.gap  = 0;
                expected_results.push_back(apply_command(w));
                taken_cnt++;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL glyph_cache_set_assoc_fifo_unit");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int n;
        int k;
        int roll;
        int gap;
        int set_idx;
        int focus[3];
        bit calm;
        tag_t t;
        logic [$bits(tag_t)-1:0] flip;

        clear_directory();

        // Directed part: empty lookup, code zero, extremes, duplicates, wrap, no-op, clear.
        add_word(OP_LOOKUP, '0, '0, '0, $urandom_range(0, GAP_MAX));
        add_word(OP_INSERT, '0, '0, '0, $urandom_range(0, GAP_MAX));
        add_word(OP_LOOKUP, '0, '0, '0, $urandom_range(0, GAP_MAX));
        add_word(OP_INSERT, CODE_MAX, ATTR_ONES, ATTR_ONES, $urandom_range(0, GAP_MAX));
        add_word(OP_INSERT, CODE_MAX, ATTR_ONES, ATTR_ONES, $urandom_range(0, GAP_MAX));
        add_word(OP_LOOKUP, CODE_MAX, ATTR_ONES, ATTR_ONES, $urandom_range(0, GAP_MAX));
        add_word(OP_LOOKUP, CODE_MAX, ATTR_ONES, ATTR_ONES - 1, $urandom_range(0, GAP_MAX));
        add_word(OP_SPARE, CODE_MAX, ATTR_ONES, ATTR_ONES, $urandom_range(0, GAP_MAX));
        // Fill the top set and wrap its pointer, evicting the first copy of the max tag.
        for (k = 1; k <= WAYS - 1; k++)
        begin
            add_word(OP_INSERT, CODE_W'((SETS - 1) + SETS * k), $urandom, $urandom,
                     $urandom_range(0, GAP_MAX));
        end
        add_word(OP_LOOKUP, CODE_MAX, ATTR_ONES, ATTR_ONES, $urandom_range(0, GAP_MAX));
        add_word(OP_CLEAR, CODE_W'($urandom), $urandom, $urandom, $urandom_range(0, GAP_MAX));
        add_word(OP_LOOKUP, '0, '0, '0, $urandom_range(0, GAP_MAX));

        // Random part: traffic concentrated on a few sets so that hits and wraps are common.
        calm = 1'b0;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 100 == 0)
            begin
                for (k = 0; k < 3; k++)
                begin
                    focus[k] = $urandom_range(0, SETS - 1);
                end
            end
            if (n % 50 == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
            end
            gap     = calm ? 0 : $urandom_range(0, GAP_MAX);
            roll    = $urandom_range(0, 99);
            set_idx = focus[$urandom_range(0, 2)];
            t.code  = CODE_W'($urandom);
            t.code  = {t.code[CODE_W-1:SET_W], SET_W'(set_idx)};
            t.fg    = $urandom;
            t.bg    = $urandom;
            if (roll < 2)
            begin
                add_word(OP_CLEAR, t.code, t.fg, t.bg, gap);
            end
            else if (roll < 4)
            begin
                add_word(OP_SPARE, t.code, t.fg, t.bg, gap);
            end
            else if (roll < 35)
            begin
                // Some inserts repeat a tag that may still be present.
                if (recent_tags.size() > 0 && $urandom_range(0, 3) == 0)
                begin
                    t = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
                end
                add_word(OP_INSERT, t.code, t.fg, t.bg, gap);
                remember_tag(t);
            end
            else
            begin
                k = $urandom_range(0, 99);
                if (recent_tags.size() > 0 && k < 75)
                begin
                    t = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
                    // Near miss: one tag bit differs from a stored tag.
                    if (k >= 55)
                    begin
                        flip = '0;
                        flip[$urandom_range(0, $bits(tag_t) - 1)] = 1'b1;
                        t = t ^ flip;
                    end
                end
                add_word(OP_LOOKUP, t.code, t.fg, t.bg, gap);
            end
        end

        // Reset, then let the block run its clearing pass before the first word.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || taken_cnt != sent_cnt)
        begin
            @(posedge clk);
        end
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("PASS glyph_cache_set_assoc_fifo_unit");
        end
        else
        begin
            $display("FAIL glyph_cache_set_assoc_fifo_unit");
        end
        $finish;
    end

endmodule

>>> glyph_cache_set_assoc_fifo_unit.f
src/glyc_pkg.sv
src/glyc_tag_unit.sv
src/glyc_set_unit.sv
src/glyph_cache_set_assoc_fifo_unit.sv
verif/tb.sv
